// ----- hw/rtl/sdhi_pkg.sv -----
// ----------------------------------------------------------------------------
// sdhi_pkg
// Shared types and constants of the strip detector hit integrator.
// ----------------------------------------------------------------------------
package sdhi_pkg;

    typedef enum logic [1:0] {
        CMD_CAL   = 2'd0,
        CMD_MEAS  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    localparam logic [2:0] REG_FIRST = 3'd0;
    localparam logic [2:0] REG_END   = 3'd1;
    localparam logic [2:0] REG_XT    = 3'd2;
    localparam logic [2:0] REG_THR   = 3'd3;
    localparam logic [2:0] REG_NOISE = 3'd4;
    localparam logic [2:0] REG_SHIFT = 3'd5;

    localparam int CHANNELS = 64;

    localparam int PED_W   = 30;
    localparam int ISUM_W  = 40;
    localparam int FRM_W   = 20;
    localparam int NOISE_W = 21;
    localparam int MEAN_W  = 32;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SAMPLE,
        ST_CLR,
        ST_WALK_RD,
        ST_WALK_WR,
        ST_RD_WAIT,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage

// ----- hw/rtl/strip_detector_hit_integrator_top.sv -----
// ----------------------------------------------------------------------------
// strip_detector_hit_integrator_top
// Pedestal calibration, crosstalk correction and hit integration per strip.
// ----------------------------------------------------------------------------
// Usage: items (command, channel, adc, last_in_frame) enter on i_valid when
// o_stall is low. Results leave on o_valid, held while i_stall is high.
// A calibration or measurement sample reads the memory, then modifies and
// writes back. Frame end walks the gated channels, each with a read of the
// corrected buffer and intensity sum, then a write; a rejected frame skips
// the walk. A read of a channel mean runs a bit-serial divider, skipped when
// no frame was accepted. Clear sweeps the intensity memory one entry a cycle.
// After reset a clearing pass zeroes the pedestal and intensity memories; no
// item is accepted meanwhile, configuration writes are. The result sits in an
// output register; the block keeps taking items while it waits and holds only
// in the step that makes the next result, until the register is free.
// ----------------------------------------------------------------------------
module strip_detector_hit_integrator_top
    import sdhi_pkg::*;
#(
    parameter int ADC_BITS = 14
)(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_index,
    input  logic [19:0]  i_cfg_data,
    input  logic         i_valid,
    output logic         o_stall,
    input  logic [1:0]   i_command,
    input  logic [5:0]   i_channel,
    input  logic [ADC_BITS-1:0] i_adc,
    input  logic         i_last_in_frame,
    output logic         o_valid,
    input  logic         i_stall,
    output logic         o_kind,
    output logic         o_frame_accepted,
    output logic [6:0]   o_hits_in_frame,
    output logic [5:0]   o_out_channel,
    output logic [31:0]  o_mean_intensity,
    output logic [19:0]  o_frames_used
);
    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CW = $clog2(CHANNELS + 1);
    localparam logic [PED_W-1:0] ADC_MAX = PED_W'((1 << ADC_BITS) - 1);

    // configuration
    logic [5:0]  r_first;
    logic [6:0]  r_end;
    logic signed [15:0] r_xt;
    logic [13:0] r_thr;
    logic [19:0] r_nlim;
    logic [4:0]  r_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 6'd2; r_end <= 7'd64; r_xt <= '0;
            r_thr <= '0; r_nlim <= 20'hFFFFF; r_shift <= 5'd13;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FIRST: r_first <= i_cfg_data[5:0];
                REG_END:   r_end   <= i_cfg_data[6:0];
                REG_XT:    r_xt    <= i_cfg_data[15:0];
                REG_THR:   r_thr   <= i_cfg_data[13:0];
                REG_NOISE: r_nlim  <= i_cfg_data;
                REG_SHIFT: r_shift <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // memories
    logic [PED_W-1:0]  m_ped  [CHANNELS];
    logic [15:0]       m_corr [CHANNELS];
    logic [ISUM_W-1:0] m_isum [CHANNELS];
    logic [PED_W-1:0]  r_ped_q;
    logic [15:0]       r_corr_q;
    logic [ISUM_W-1:0] r_isum_q;

    logic              n_ped_we, n_corr_we, n_isum_we;
    logic [AW-1:0]     n_ped_wa, n_isum_wa, n_corr_wa, n_rd_a, n_isum_ra;
    logic [PED_W-1:0]  n_ped_wd;
    logic [15:0]       n_corr_wd;
    logic [ISUM_W-1:0] n_isum_wd;

    always_ff @(posedge i_clk) begin
        if (n_ped_we)  m_ped[n_ped_wa]   <= n_ped_wd;
        if (n_corr_we) m_corr[n_corr_wa] <= n_corr_wd;
        if (n_isum_we) m_isum[n_isum_wa] <= n_isum_wd;
        r_ped_q  <= m_ped[n_rd_a];
        r_corr_q <= m_corr[n_rd_a];
        r_isum_q <= m_isum[n_isum_ra];
    end

    // control state
    t_state r_st, n_st;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_init, n_init;
    logic [1:0]    r_cmd;
    logic [5:0]    r_ch;
    logic [ADC_BITS-1:0] r_adc;
    logic          r_last;
    logic signed [14:0] r_prev, n_prev;
    logic [NOISE_W-1:0] r_noise, n_noise;
    logic [FRM_W-1:0]   r_frames, n_frames;
    logic          r_ok, n_ok;
    logic [6:0]    r_hits, n_hits;
    logic          r_ov, n_ov;
    logic          r_okind, n_okind;
    logic          r_oacc, n_oacc;
    logic [6:0]    r_ohits, n_ohits;
    logic [5:0]    r_och, n_och;
    logic [31:0]   r_omean, n_omean;
    logic [19:0]   r_ofr, n_ofr;

    logic          acc;
    logic          out_free;
    assign acc = i_valid && !o_stall;
    assign o_stall = (r_st != ST_IDLE) || r_init;
    // output register can take a new result at this edge
    assign out_free = !r_ov || !i_stall;

    logic [6:0] gate_end;
    assign gate_end = (r_end < 7'(CHANNELS)) ? r_end : 7'(CHANNELS);
    logic ch_in;
    assign ch_in = ({1'b0, r_ch} < 7'(CHANNELS));

    // sample arithmetic
    logic [PED_W-1:0] ped_sh, ped;
    logic signed [PED_W+1:0] dev_w;
    logic signed [14:0] dev;
    logic signed [31:0] xt_prod;
    logic signed [17:0] xt;
    logic signed [18:0] corr_w;
    logic [14:0] absd;
    logic [NOISE_W:0] noise_sum;
    logic [PED_W:0] psum;
    logic gated;

    always_comb begin
        ped_sh = r_ped_q >> r_shift;
        ped    = (ped_sh > ADC_MAX) ? ADC_MAX : ped_sh;
        dev_w  = $signed({2'b0, PED_W'(r_adc)}) - $signed({2'b0, ped});
        if (dev_w < -16384) dev = -15'sd16384;
        else if (dev_w > 16383) dev = 15'sd16383;
        else dev = dev_w[14:0];
        xt_prod = r_prev * r_xt + 32'sd8192;
        xt      = xt_prod[31:14];
        corr_w  = 19'(dev) - 19'(xt);
        absd    = dev[14] ? 15'(-dev) : 15'(dev);
        noise_sum = {1'b0, r_noise} + (NOISE_W+1)'(absd);
        psum   = {1'b0, r_ped_q} + (PED_W+1)'(r_adc);
        gated  = ({1'b0, r_ch} >= {1'b0, r_first}) && ({1'b0, r_ch} < gate_end);
    end

    // divider
    logic div_start, div_done;
    logic [ISUM_W+7:0] div_q;
    sdhi_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num({r_isum_q, 8'd0}), .i_den(r_frames),
        .o_done(div_done), .o_quot(div_q)
    );

    logic signed [16:0] wc;
    logic [ISUM_W:0] isum_add;
    assign wc = {r_corr_q[15], r_corr_q};
    assign isum_add = {1'b0, r_isum_q} + (ISUM_W+1)'(r_corr_q);

    always_comb begin
        n_st = r_st; n_cnt = r_cnt; n_init = r_init;
        n_prev = r_prev; n_noise = r_noise; n_frames = r_frames;
        n_ok = r_ok; n_hits = r_hits;
        n_ov = r_ov; n_okind = r_okind; n_oacc = r_oacc; n_ohits = r_ohits;
        n_och = r_och; n_omean = r_omean; n_ofr = r_ofr;
        n_ped_we = 1'b0; n_corr_we = 1'b0; n_isum_we = 1'b0;
        n_ped_wa = r_ch[AW-1:0]; n_corr_wa = r_ch[AW-1:0];
        n_isum_wa = r_cnt[AW-1:0];
        n_ped_wd = '0; n_corr_wd = corr_w[15:0]; n_isum_wd = '0;
        n_rd_a = i_channel[AW-1:0]; n_isum_ra = i_channel[AW-1:0];
        div_start = 1'b0;
        if (r_ov && !i_stall) n_ov = 1'b0;

        if (r_init) begin
            n_ped_we = 1'b1; n_isum_we = 1'b1;
            n_ped_wa = r_cnt[AW-1:0];
            if (r_cnt == CW'(CHANNELS - 1)) n_init = 1'b0;
            n_cnt = r_cnt + 1'b1;
        end else begin
            case (r_st)
                ST_IDLE: begin
                    if (acc) begin
                        case (t_cmd'(i_command))
                            CMD_CAL, CMD_MEAS: n_st = ST_SAMPLE;
                            CMD_READ:          n_st = ST_RD_WAIT;
                            default: begin
                                n_st = ST_CLR; n_cnt = '0; n_frames = '0;
                            end
                        endcase
                    end
                end
                ST_SAMPLE: begin
                    if (t_cmd'(r_cmd) == CMD_CAL) begin
                        n_st = ST_IDLE;
                        if (ch_in) begin
                            n_ped_we = 1'b1;
                            n_ped_wd = psum[PED_W] ? '1 : psum[PED_W-1:0];
                        end
                    end else begin
                        if (ch_in) begin
                            if (gated) begin
                                n_corr_we = 1'b1;
                                if (corr_w > 32767) n_corr_wd = 16'h7FFF;
                                else if (corr_w < -32768) n_corr_wd = 16'h8000;
                                n_noise = noise_sum[NOISE_W] ? '1
                                                             : noise_sum[NOISE_W-1:0];
                            end
                            n_prev = dev;
                        end
                        if (r_last) begin
                            n_ok   = (gated && ch_in ? (noise_sum[NOISE_W] ? '1
                                     : noise_sum[NOISE_W-1:0]) : r_noise)
                                     < NOISE_W'(r_nlim);
                            n_hits = '0;
                            n_cnt  = CW'(r_first);
                            n_st   = ST_WALK_RD;
                        end else begin
                            n_st = ST_IDLE;
                        end
                    end
                end
                ST_WALK_RD: begin
                    n_rd_a = r_cnt[AW-1:0]; n_isum_ra = r_cnt[AW-1:0];
                    if (!r_ok || ({1'b0, r_cnt} >= {1'b0, gate_end})) begin
                        // hold until the output register is free
                        if (out_free) begin
                            n_ov = 1'b1; n_okind = 1'b0; n_oacc = r_ok;
                            n_ohits = r_hits; n_och = '0; n_omean = '0;
                            n_frames = (r_ok && r_frames != '1) ? r_frames + 1'b1
                                                                : r_frames;
                            n_ofr = n_frames;
                            n_noise = '0; n_prev = '0;
                            n_st = ST_IDLE;
                        end
                    end else begin
                        n_st = ST_WALK_WR;
                    end
                end
                ST_WALK_WR: begin
                    if (wc > 17'sd0 && wc > $signed({3'b0, r_thr})) begin
                        n_isum_we = 1'b1;
                        n_isum_wd = isum_add[ISUM_W] ? '1 : isum_add[ISUM_W-1:0];
                        n_hits = r_hits + 1'b1;
                    end
                    n_cnt = r_cnt + 1'b1;
                    n_st = ST_WALK_RD;
                end
                ST_CLR: begin
                    n_isum_we = 1'b1;
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt == CW'(CHANNELS - 1)) n_st = ST_IDLE;
                end
                ST_RD_WAIT: begin
                    n_rd_a = r_ch[AW-1:0]; n_isum_ra = r_ch[AW-1:0];
                    if (!out_free) begin
                        n_st = ST_RD_WAIT;
                    end else if (!ch_in || r_frames == '0) begin
                        n_ov = 1'b1; n_okind = 1'b1; n_oacc = 1'b0; n_ohits = '0;
                        n_och = r_ch; n_omean = '0; n_ofr = r_frames;
                        n_st = ST_IDLE;
                    end else begin
                        div_start = 1'b1;
                        n_st = ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        n_ov = 1'b1; n_okind = 1'b1; n_oacc = 1'b0; n_ohits = '0;
                        n_och = r_ch; n_ofr = r_frames;
                        n_omean = (|div_q[ISUM_W+7:MEAN_W]) ? '1 : div_q[MEAN_W-1:0];
                        n_st = ST_IDLE;
                    end
                end
                default: n_st = ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_cnt <= '0; r_init <= 1'b1;
            r_prev <= '0; r_noise <= '0; r_frames <= '0;
            r_ok <= 1'b0; r_hits <= '0; r_ov <= 1'b0;
        end else begin
            r_st <= n_st; r_cnt <= n_cnt; r_init <= n_init;
            r_prev <= n_prev; r_noise <= n_noise; r_frames <= n_frames;
            r_ok <= n_ok; r_hits <= n_hits; r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_okind <= n_okind; r_oacc <= n_oacc; r_ohits <= n_ohits;
        r_och <= n_och; r_omean <= n_omean; r_ofr <= n_ofr;
        if (acc) begin
            r_cmd <= i_command; r_ch <= i_channel;
            r_adc <= i_adc; r_last <= i_last_in_frame;
        end
    end

    assign o_valid = r_ov;
    assign o_kind = r_okind;
    assign o_frame_accepted = r_oacc;
    assign o_hits_in_frame = r_ohits;
    assign o_out_channel = r_och;
    assign o_mean_intensity = r_omean;
    assign o_frames_used = r_ofr;
endmodule

// ----- hw/rtl/sdhi_divider.sv -----
// ----------------------------------------------------------------------------
// sdhi_divider
// Restoring divider, one quotient bit per cycle, 48-bit dividend by 20 bits.
// ----------------------------------------------------------------------------
module sdhi_divider
    import sdhi_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [ISUM_W+7:0]    i_num,
    input  logic [FRM_W-1:0]     i_den,
    output logic                 o_done,
    output logic [ISUM_W+7:0]    o_quot
);
    localparam int NW = ISUM_W + 8;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0]  r_q;
    logic [FRM_W:0] r_rem;
    logic [CW-1:0]  r_cnt;
    logic           r_busy;
    logic [FRM_W:0] n_trial;

    assign n_trial = {r_rem[FRM_W-1:0], r_q[NW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(NW);
            r_q    <= i_num;
            r_rem  <= '0;
        end else if (r_busy) begin
            if (n_trial >= {1'b0, i_den}) begin
                r_rem <= n_trial - {1'b0, i_den};
                r_q   <= {r_q[NW-2:0], 1'b1};
            end else begin
                r_rem <= n_trial;
                r_q   <= {r_q[NW-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) r_busy <= 1'b0;
        end
    end

    assign o_done = r_busy && (r_cnt == CW'(1));
    assign o_quot = (n_trial >= {1'b0, i_den}) ? {r_q[NW-2:0], 1'b1}
                                               : {r_q[NW-2:0], 1'b0};
endmodule
